[hdl/lcb_pkg.sv]
`default_nettype none

package lcb_pkg;

  // field and stream widths
  localparam int CARD_W      = 54;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  // bcd register: seventeen digits cover any 54-bit value
  localparam int BCD_DIGITS  = 17;
  localparam int BCD_W       = 4 * BCD_DIGITS;

  // conversion consumes two binary bits a cycle
  localparam int CONV_STEPS  = CARD_W / 2;
  localparam int CNT_W       = 5;

  localparam logic [CNT_W-1:0] LAST_CONV = CNT_W'(CONV_STEPS - 1);
  localparam logic [CNT_W-1:0] LAST_SUM  = CNT_W'(BCD_DIGITS - 1);

  // brand codes
  typedef enum logic [2:0] {
    BRAND_NONE   = 3'd0,
    BRAND_P34_37 = 3'd1,
    BRAND_P4     = 3'd2,
    BRAND_P51_55 = 3'd3,
    BRAND_P5_6   = 3'd4
  } brand_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic conv;
    logic sum;
    logic store;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic conv_last;
    logic sum_last;
  } sts_t;

  // one double-dabble step: add three to each digit of five or more, then shift
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic b_in);
    logic [BCD_W-1:0] adj;
    int i;
    adj = bcd;
    for (i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = 4'(bcd[4*i +: 4] + 4'd3);
      end
    end
    return {adj[BCD_W-2:0], b_in};
  endfunction

endpackage

`default_nettype wire

[hdl/lcb_ctrl.sv]
`default_nettype none

module lcb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire lcb_pkg::sts_t sts,
  output lcb_pkg::cmd_t      cmd
);
  import lcb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SUM  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  // command decode
  always_comb begin
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    cmd.load  = in_tready && in_tvalid;
    cmd.conv  = (state_r == S_CONV);
    cmd.sum   = (state_r == S_SUM);
    cmd.store = (state_r == S_DONE) && (!out_vld_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (sts.conv_last) state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sts.sum_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd.store) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result word held until taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.store) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  assign out_tvalid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  a_store_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> state_r == S_DONE) else $error("store outside done state");

  a_load_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_CONV) else $error("accepted word did not start conversion");

  a_conv_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && sts.conv_last) |=> state_r == S_SUM)
    else $error("conversion end did not start digit sum");

endmodule

`default_nettype wire

[hdl/lcb_dp.sv]
`default_nettype none

module lcb_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [lcb_pkg::CARD_W-1:0] card_number,
  input  wire lcb_pkg::cmd_t              cmd,
  output lcb_pkg::sts_t                   sts,
  output lcb_pkg::brand_t                 brand,
  output logic                            luhn_ok
);
  import lcb_pkg::*;

  logic [CARD_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [3:0]        acc_r, acc_nxt;
  brand_t            cls_r, cls_nxt;
  brand_t            brand_r, brand_nxt;
  logic              ok_r, ok_nxt;

  logic [BCD_W-1:0]  bcd_half;
  logic [3:0]        dig;
  logic [4:0]        dig_x2;
  logic [4:0]        dig_val;
  logic [4:0]        acc_sum;
  logic [3:0]        d13, d14, d15, d16;
  brand_t            cls_now;

  assign sts.conv_last = cmd.conv && (cnt_r == LAST_CONV);
  assign sts.sum_last  = cmd.sum && (cnt_r == LAST_SUM);

  // two dabble steps per cycle, msb first
  assign bcd_half = dabble_step(bcd_r, bin_r[CARD_W-1]);

  // luhn weight of the current digit: odd places are doubled, nine off above nine
  assign dig    = bcd_r[3:0];
  assign dig_x2 = {dig, 1'b0};
  always_comb begin
    if (!cnt_r[0]) dig_val = {1'b0, dig};
    else if (dig_x2 > 5'd9) dig_val = 5'(dig_x2 - 5'd9);
    else dig_val = dig_x2;
  end
  assign acc_sum = {1'b0, acc_r} + dig_val;

  // prefix class from the leading digits
  assign d13 = bcd_r[4*13 +: 4];
  assign d14 = bcd_r[4*14 +: 4];
  assign d15 = bcd_r[4*15 +: 4];
  assign d16 = bcd_r[4*16 +: 4];
  always_comb begin
    cls_now = BRAND_NONE;
    if (d16 == 4'd0 && d15 == 4'd0 && d14 == 4'd3 && (d13 == 4'd4 || d13 == 4'd7)) begin
      cls_now = BRAND_P34_37;
    end else if ((d16 == 4'd0 && d15 == 4'd0 && d14 == 4'd0 && d13 == 4'd0 &&
                  bcd_r[4*12 +: 4] == 4'd4) || (d16 == 4'd0 && d15 == 4'd4)) begin
      cls_now = BRAND_P4;
    end else if (d16 == 4'd0 && d15 == 4'd5 && d14 inside {[4'd1:4'd5]}) begin
      cls_now = BRAND_P51_55;
    end else if (d16 == 4'd0 && (d15 == 4'd5 || d15 == 4'd6)) begin
      cls_now = BRAND_P5_6;
    end
  end

  // sequencing of the datapath registers
  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    cls_nxt   = cls_r;
    brand_nxt = brand_r;
    ok_nxt    = ok_r;
    if (cmd.load) begin
      bin_nxt = card_number;
      bcd_nxt = '0;
      cnt_nxt = '0;
      acc_nxt = '0;
    end else if (cmd.conv) begin
      bcd_nxt = dabble_step(bcd_half, bin_r[CARD_W-2]);
      bin_nxt = {bin_r[CARD_W-3:0], 2'b00};
      cnt_nxt = sts.conv_last ? '0 : CNT_W'(cnt_r + 1'b1);
    end else if (cmd.sum) begin
      if (cnt_r == '0) cls_nxt = cls_now;
      acc_nxt = (acc_sum >= 5'd10) ? 4'(acc_sum - 5'd10) : acc_sum[3:0];
      bcd_nxt = {4'd0, bcd_r[BCD_W-1:4]};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (cmd.store) begin
      ok_nxt    = (acc_r == 4'd0);
      brand_nxt = (acc_r == 4'd0) ? cls_r : BRAND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    acc_r   <= acc_nxt;
    cls_r   <= cls_nxt;
    brand_r <= brand_nxt;
    ok_r    <= ok_nxt;
  end

  assign brand   = brand_r;
  assign luhn_ok = ok_r;

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cnt_r == '0 && acc_r == 4'd0)) else $error("load did not clear sum state");

  a_brand_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> (brand_r == BRAND_NONE || ok_r)) else $error("brand given to failed number");

  a_acc_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum |=> acc_r <= 4'd9) else $error("digit sum left decimal range");

endmodule

`default_nettype wire

[hdl/luhn_check_card_brand.sv]
// an accepted word goes through conversion, digit sum and store before out_tvalid rises
// one word at a time: in_tready stays low from accept until the result is stored;
//   the binary-to-bcd loop runs at two bits a cycle and the digit sum at one digit a cycle
// a new word is taken while the previous result still waits in the output register
// reset: synchronous, active low; clears the controller and output valid, no result pending
`default_nettype none

module luhn_check_card_brand (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lcb_pkg::IN_TDATA_W-1:0] in_tdata,   // [53:0] card_number
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [lcb_pkg::OUT_TDATA_W-1:0]     out_tdata   // [2:0] brand, [3] luhn_ok
);
  import lcb_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  brand_t brand;
  logic   luhn_ok;

  // sequencer
  lcb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // conversion, digit sum and prefix decode
  lcb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .card_number (in_tdata[CARD_W-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .brand       (brand),
    .luhn_ok     (luhn_ok)
  );

  // pack the result word
  assign out_tdata = {(OUT_TDATA_W - 4)'(0), luhn_ok, brand};

endmodule

`default_nettype wire
